@@ rtl/gblur_pkg.sv @@
// Shared types, constants and register codes for the 11x11 RGB Gaussian blur.
// No dependencies; every other rtl file but gblur_ram imports this package.
package gblur_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_WINDOW_SIZE = 11;
  localparam int MAX_HEIGHT      = 4096;

  localparam int NCH        = 3;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = NCH * CHAN_W;
  localparam int NUM_W      = 6;
  localparam int WGT_W      = 16;
  localparam int WI_W       = 3;
  localparam int SLOT_W     = 4;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int CFGW_W     = 11;
  localparam int PIXCOL_W   = 10;
  localparam int OUT_W      = 16;
  localparam int FRAC_SHIFT = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0     = 3'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [CFGW_W-1:0] RST_FRAME_WIDTH  = 11'd512;
  localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = 13'd512;

  typedef logic [NUM_W-1:0][WGT_W-1:0] wgt_vec_t;

  localparam wgt_vec_t RST_WEIGHTS = {16'd577, 16'd1779, 16'd4268,
                                      16'd7972, 16'd11600, 16'd13144};

  // Control that rides along the cell chain with each column request.
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic              ctr;
    logic [WI_W-1:0]   dxw;
    logic [SLOT_W-1:0] rslot;
  } gb_ctl_t;

endpackage

@@ rtl/gblur_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by every line cell.
module gblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/gblur_cell.sv @@
// One line cell: holds one ring row of the line store and adds its weighted
// pixel into the vertical column sum passed along the chain. Uses gblur_pkg, gblur_ram.
module gblur_cell
  import gblur_pkg::*;
#(
  parameter int CELL_IDX  = 0,
  parameter int RING      = 11,
  parameter int HALF      = 5,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int VW        = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wgt_vec_t                     wgt,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [PIX_W-1:0]             wr_data,
  input  gb_ctl_t                      ctl_in,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_in,
  input  logic [NCH-1:0][VW-1:0]       sum_in,
  input  logic [PIX_W-1:0]             ctr_in,
  output gb_ctl_t                      ctl_out,
  output logic [$clog2(MAX_WIDTH)-1:0] col_out,
  output logic [NCH-1:0][VW-1:0]       sum_out,
  output logic [PIX_W-1:0]             ctr_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0]          rd_data;
  gb_ctl_t                   ctl_s1_r, ctl_out_r;
  logic [COL_W-1:0]          col_s1_r, col_out_r;
  logic [NCH-1:0][VW-1:0]    sum_s1_r, sum_out_r, sum_nxt;
  logic [PIX_W-1:0]          ctr_s1_r, ctr_out_r, ctr_nxt;
  logic [SLOT_W-1:0]         ring_dist;
  logic [WI_W-1:0]           wi;
  logic [WGT_W-1:0]          w_sel;
  logic [CHAN_W+WGT_W-1:0]   prod [NCH];

  gblur_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_col),
    .wr_data (wr_data),
    .rd_addr (col_in),
    .rd_data (rd_data)
  );

  // Row distance from this cell's ring slot to the output row, folded to |dy|.
  always_comb begin
    if (SLOT_W'(CELL_IDX) >= ctl_s1_r.rslot) begin
      ring_dist = SLOT_W'(CELL_IDX) - ctl_s1_r.rslot;
    end else begin
      ring_dist = SLOT_W'(CELL_IDX) + SLOT_W'(RING) - ctl_s1_r.rslot;
    end
    if (ring_dist <= SLOT_W'(HALF)) begin
      wi = WI_W'(ring_dist);
    end else begin
      wi = WI_W'(SLOT_W'(RING) - ring_dist);
    end
    w_sel = wgt[wi];
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch]    = rd_data[ch*CHAN_W +: CHAN_W] * w_sel;
      sum_nxt[ch] = sum_s1_r[ch] + VW'(prod[ch]);
    end
    if (ctl_s1_r.ctr && (ctl_s1_r.rslot == SLOT_W'(CELL_IDX))) begin
      ctr_nxt = rd_data;
    end else begin
      ctr_nxt = ctr_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r  <= '0;
      ctl_out_r <= '0;
    end else begin
      ctl_s1_r  <= ctl_in;
      ctl_out_r <= ctl_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    col_s1_r  <= col_in;
    sum_s1_r  <= sum_in;
    ctr_s1_r  <= ctr_in;
    col_out_r <= col_s1_r;
    sum_out_r <= sum_nxt;
    ctr_out_r <= ctr_nxt;
  end

  assign ctl_out = ctl_out_r;
  assign col_out = col_out_r;
  assign sum_out = sum_out_r;
  assign ctr_out = ctr_out_r;

endmodule

@@ rtl/gblur_hacc.sv @@
// Horizontal pass: weights each column sum, accumulates across the window,
// then rounds and saturates to Q8.8. Uses gblur_pkg.
module gblur_hacc
  import gblur_pkg::*;
#(
  parameter int VW = 28,
  parameter int AW = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  wgt_vec_t                  wgt,
  input  gb_ctl_t                   ctl_in,
  input  logic [NCH-1:0][VW-1:0]    sum_in,
  input  logic [PIX_W-1:0]          ctr_in,
  output logic                      res_vld,
  output logic [NCH-1:0][OUT_W-1:0] res,
  output logic [PIX_W-1:0]          ctr_pix
);

  localparam logic [AW:0] ROUND_BIAS = (AW+1)'(1) << (FRAC_SHIFT - 1);

  gb_ctl_t                   ctl_a_r;
  logic [VW+WGT_W-1:0]       prod_a_r [NCH];
  logic [AW-1:0]             acc_r [NCH];
  logic                      res_vld_r;
  logic [PIX_W-1:0]          ctr_r;
  logic [AW:0]               rnd [NCH];
  logic [AW:0]               quo [NCH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      ctl_a_r <= ctl_in;
      if (clr) begin
        res_vld_r <= 1'b0;
      end else if (ctl_a_r.vld && ctl_a_r.last) begin
        res_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod_a_r[ch] <= sum_in[ch] * wgt[ctl_in.dxw];
      if (ctl_a_r.vld) begin
        if (ctl_a_r.first) begin
          acc_r[ch] <= AW'(prod_a_r[ch]);
        end else begin
          acc_r[ch] <= acc_r[ch] + AW'(prod_a_r[ch]);
        end
      end
    end
    if (ctl_in.vld && ctl_in.ctr) begin
      ctr_r <= ctr_in;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      rnd[ch] = (AW+1)'(acc_r[ch]) + ROUND_BIAS;
      quo[ch] = rnd[ch] >> FRAC_SHIFT;
      if (|quo[ch][AW:OUT_W]) begin
        res[ch] = '1;
      end else begin
        res[ch] = quo[ch][OUT_W-1:0];
      end
    end
  end

  assign res_vld = res_vld_r;
  assign ctr_pix = ctr_r;

endmodule

@@ rtl/gaussian_blur_11x11_rgb.sv @@
// Flow: an item with no result is taken at once. An item that emits a pixel
//   stalls the input while RING column requests pass the line cells and the
//   horizontal accumulator and until the result is loaded into a free output
//   register. One item is worked on at a time.
// Reset (rst_n, synchronous): clears counters and valids, sets config to
//   defaults. The line store is not cleared; stale reads reach only border sums.
module gaussian_blur_11x11_rgb
  import gblur_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [CHAN_W-1:0]     in_chan_b,
  input  logic [CHAN_W-1:0]     in_chan_g,
  input  logic [CHAN_W-1:0]     in_chan_r,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_pix_row,
  output logic [PIXCOL_W-1:0]   out_pix_col,
  output logic [OUT_W-1:0]      out_blur_b,
  output logic [OUT_W-1:0]      out_blur_g,
  output logic [OUT_W-1:0]      out_blur_r,
  output logic                  out_frame_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int RING  = 2 * HALF + 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LW    = COL_W + 1;
  localparam int J_W   = $clog2(RING);
  localparam int VW    = CHAN_W + WGT_W + $clog2(RING);
  localparam int AW    = VW + WGT_W + $clog2(RING);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  // Configuration.
  logic [CFGW_W-1:0] frame_width_r;
  logic [HGT_W-1:0]  frame_height_r;
  wgt_vec_t          weights_r;

  // Frame bookkeeping.
  logic [LW-1:0]     lat_w_r, lat_w_nxt, clamp_w, eff_w;
  logic [HGT_W-1:0]  lat_h_r, lat_h_nxt, clamp_h, eff_h;
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic              in_done_r, in_done_nxt;
  logic              frame_idle, lag_ok, at_last, job_int;

  // Job under way.
  logic [COL_W-1:0]  job_col_r, job_col_nxt;
  logic [ROW_W-1:0]  job_row_r, job_row_nxt;
  logic [SLOT_W-1:0] job_slot_r, job_slot_nxt;
  logic              job_int_r, job_int_nxt, job_last_r, job_last_nxt;

  state_t            state_r, state_nxt;
  logic [J_W-1:0]    j_r, j_nxt;

  logic              in_acc, is_pix, wr_en, emit, out_free, load;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]          out_pix_row_r;
  logic [PIXCOL_W-1:0]       out_pix_col_r;
  logic [NCH-1:0][OUT_W-1:0] out_blur_r_r;
  logic                      out_frame_last_r;

  // Cell chain wiring.
  gb_ctl_t                   ctl_c [RING+1];
  logic [COL_W-1:0]          col_c [RING+1];
  logic [NCH-1:0][VW-1:0]    sum_c [RING+1];
  logic [PIX_W-1:0]          ctr_c [RING+1];
  logic [PIX_W-1:0]          wr_data;

  logic                      res_vld;
  logic [NCH-1:0][OUT_W-1:0] res;
  logic [PIX_W-1:0]          ctr_pix;

  // ---------------------------------------------------------------------------
  // Configuration port: plain writes, no read-back.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      weights_r      <= RST_WEIGHTS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[CFGW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[HGT_W-1:0];
        default:          weights_r[WI_W'(cfg_index - REG_WEIGHT_0)] <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame size: clamp the registers, latch them when a frame starts.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (32'(frame_width_r) < WINDOW_SIZE) begin
      clamp_w = LW'(WINDOW_SIZE);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      clamp_w = LW'(MAX_WIDTH);
    end else begin
      clamp_w = LW'(frame_width_r);
    end
    if (32'(frame_height_r) < WINDOW_SIZE) begin
      clamp_h = HGT_W'(WINDOW_SIZE);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      clamp_h = HGT_W'(MAX_HEIGHT);
    end else begin
      clamp_h = frame_height_r;
    end
  end

  assign frame_idle = !in_done_r && (in_row_r == '0) && (in_col_r == '0) &&
                      (out_row_r == '0) && (out_col_r == '0);
  assign eff_w = frame_idle ? clamp_w : lat_w_r;
  assign eff_h = frame_idle ? clamp_h : lat_h_r;

  // ---------------------------------------------------------------------------
  // Request decode. One request at a time: stall while a result is in flight.
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_pix   = (in_req_type == REQ_PIXEL);
  assign wr_en    = in_acc && is_pix && !in_done_r;
  assign wr_data  = {in_chan_r, in_chan_g, in_chan_b};

  // The stream is far enough ahead once HALF rows plus HALF pixels are in.
  assign lag_ok = (in_row_r > ROW_W'(HALF)) ||
                  ((in_row_r == ROW_W'(HALF)) && (in_col_r >= COL_W'(HALF)));
  assign emit   = in_acc && (is_pix ? (!in_done_r && lag_ok) : in_done_r);

  assign at_last = (32'(out_row_r) == 32'(eff_h) - 1) &&
                   (32'(out_col_r) == 32'(eff_w) - 1);
  assign job_int = (out_row_r >= ROW_W'(HALF)) &&
                   (32'(out_row_r) + HALF < 32'(eff_h)) &&
                   (out_col_r >= COL_W'(HALF)) &&
                   (32'(out_col_r) + HALF < 32'(eff_w));

  always_comb begin
    lat_w_nxt    = lat_w_r;
    lat_h_nxt    = lat_h_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    in_done_nxt  = in_done_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    job_col_nxt  = job_col_r;
    job_row_nxt  = job_row_r;
    job_slot_nxt = job_slot_r;
    job_int_nxt  = job_int_r;
    job_last_nxt = job_last_r;

    if (in_acc && frame_idle) begin
      lat_w_nxt = clamp_w;
      lat_h_nxt = clamp_h;
    end

    // Advance the write position.
    if (wr_en) begin
      if (32'(in_col_r) == 32'(eff_w) - 1) begin
        in_col_nxt = '0;
        if (32'(in_row_r) == 32'(eff_h) - 1) begin
          in_done_nxt = 1'b1;
        end else begin
          in_row_nxt  = in_row_r + 1'b1;
          in_slot_nxt = (in_slot_r == SLOT_W'(RING - 1)) ? '0 : in_slot_r + 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end

    // Hand the next output position to the sweep, then advance it.
    if (emit) begin
      job_col_nxt  = out_col_r;
      job_row_nxt  = out_row_r;
      job_slot_nxt = out_slot_r;
      job_int_nxt  = job_int;
      job_last_nxt = at_last;
      if (at_last) begin
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        in_slot_nxt  = '0;
        in_done_nxt  = 1'b0;
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_slot_nxt = '0;
      end else if (32'(out_col_r) == 32'(eff_w) - 1) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + 1'b1;
        out_slot_nxt = (out_slot_r == SLOT_W'(RING - 1)) ? '0 : out_slot_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: sweep the window columns into the chain, wait for the sum.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == ST_WAIT) && res_vld && out_free;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    case (state_r)
      ST_IDLE: begin
        if (emit) begin
          state_nxt = ST_SWEEP;
          j_nxt     = '0;
        end
      end
      ST_SWEEP: begin
        j_nxt = j_r + 1'b1;
        if (j_r == J_W'(RING - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Chain head: one column request per sweep cycle, columns c-HALF..c+HALF.
  always_comb begin
    ctl_c[0].vld   = (state_r == ST_SWEEP);
    ctl_c[0].first = (j_r == '0);
    ctl_c[0].last  = (j_r == J_W'(RING - 1));
    ctl_c[0].ctr   = (j_r == J_W'(HALF));
    ctl_c[0].dxw   = (j_r >= J_W'(HALF)) ? WI_W'(j_r - J_W'(HALF))
                                          : WI_W'(J_W'(HALF) - j_r);
    ctl_c[0].rslot = job_slot_r;
    col_c[0]       = job_col_r + COL_W'(j_r) - COL_W'(HALF);
    sum_c[0]       = '0;
    ctr_c[0]       = '0;
  end

  for (genvar k = 0; k < RING; k++) begin : g_cell
    gblur_cell #(
      .CELL_IDX  (k),
      .RING      (RING),
      .HALF      (HALF),
      .MAX_WIDTH (MAX_WIDTH),
      .VW        (VW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wgt     (weights_r),
      .wr_en   (wr_en && (in_slot_r == SLOT_W'(k))),
      .wr_col  (in_col_r),
      .wr_data (wr_data),
      .ctl_in  (ctl_c[k]),
      .col_in  (col_c[k]),
      .sum_in  (sum_c[k]),
      .ctr_in  (ctr_c[k]),
      .ctl_out (ctl_c[k+1]),
      .col_out (col_c[k+1]),
      .sum_out (sum_c[k+1]),
      .ctr_out (ctr_c[k+1])
    );
  end

  gblur_hacc #(.VW(VW), .AW(AW)) u_hacc (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (emit),
    .wgt     (weights_r),
    .ctl_in  (ctl_c[RING]),
    .sum_in  (sum_c[RING]),
    .ctr_in  (ctr_c[RING]),
    .res_vld (res_vld),
    .res     (res),
    .ctr_pix (ctr_pix)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop valid once taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      lat_w_r     <= LW'(MAX_WIDTH);
      lat_h_r     <= HGT_W'(WINDOW_SIZE);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      in_done_r   <= 1'b0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      lat_w_r     <= lat_w_nxt;
      lat_h_r     <= lat_h_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_slot_r   <= in_slot_nxt;
      in_done_r   <= in_done_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_slot_r  <= out_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_col_r  <= job_col_nxt;
    job_row_r  <= job_row_nxt;
    job_slot_r <= job_slot_nxt;
    job_int_r  <= job_int_nxt;
    job_last_r <= job_last_nxt;
    if (load) begin
      out_pix_row_r    <= job_row_r;
      out_pix_col_r    <= PIXCOL_W'(job_col_r);
      out_frame_last_r <= job_last_r;
      for (int ch = 0; ch < NCH; ch++) begin
        // Border pixels pass through as value << 8.
        out_blur_r_r[ch] <= job_int_r ? res[ch]
                                      : {ctr_pix[ch*CHAN_W +: CHAN_W], 8'h00};
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pix_row    = out_pix_row_r;
  assign out_pix_col    = out_pix_col_r;
  assign out_blur_b     = out_blur_r_r[0];
  assign out_blur_g     = out_blur_r_r[1];
  assign out_blur_r     = out_blur_r_r[2];
  assign out_frame_last = out_frame_last_r;

`ifndef SYNTHESIS
  // The window sum completes only after the sweep has finished issuing.
  a_res_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_vld) |-> (state_r == ST_WAIT))
    else $error("window sum finished outside the wait state");

  // Outputs never run ahead of the rows written so far.
  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    !in_done_r |-> (out_row_r <= in_row_r))
    else $error("output row ahead of input row");

  // After the frame's last pixel is loaded, the frame counters are back at zero.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && job_last_r) |=> (frame_idle && !in_done_r))
    else $error("frame counters not cleared after last pixel");
`endif

endmodule
